### rtl/essr_pkg.sv
// Package for the encoder speed step regulator.
// Widths, reset values, register indexes, event codes and shared types.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package essr_pkg;

	localparam int unsigned WORD_W    = 16;
	localparam int unsigned MODE_W    = 2;
	localparam int unsigned SAMPLE_W  = 12;
	localparam int unsigned PPR_W     = 6;
	localparam int unsigned RPR_W     = 8;
	localparam int unsigned STEP_W    = 10;
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned CFG_DAT_W = 16;

	localparam logic [WORD_W-1:0] WINDOW_TICKS_RST = 16'd101;
	localparam logic [PPR_W-1:0]  PULSES_PER_REV_RST = 6'd20;
	localparam logic [RPR_W-1:0]  RPM_PER_REV_RST = 8'd60;
	localparam logic [STEP_W-1:0] DUTY_STEP_RST = 10'd10;
	localparam logic [WORD_W-1:0] DUTY_INITIAL_RST = 16'd350;
	localparam logic [WORD_W-1:0] DUTY_MAX_RST = 16'd1000;
	localparam logic [WORD_W-1:0] FULL_SCALE_RST = 16'd13000;

	localparam logic [WORD_W-1:0] WORD_MAX     = 16'hFFFF;
	localparam logic [12:0]       ADC_FULL     = 13'd4095;
	localparam logic [WORD_W-1:0] TARGET_FLOOR = 16'd100;
	localparam logic [WORD_W-1:0] TARGET_SUBST = 16'd50;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_WINDOW_TICKS   = 3'd0,
		REG_PULSES_PER_REV = 3'd1,
		REG_RPM_PER_REV    = 3'd2,
		REG_DUTY_STEP      = 3'd3,
		REG_DUTY_INITIAL   = 3'd4,
		REG_DUTY_MAX       = 3'd5,
		REG_FULL_SCALE     = 3'd6
	} cfg_idx_t;

	typedef enum logic [MODE_W-1:0] {
		MODE_TICK  = 2'd0,
		MODE_PULSE = 2'd1,
		MODE_ADC   = 2'd2
	} mode_t;

	// outcome of a closed measurement window
	typedef struct packed {
		logic [WORD_W-1:0] rpm;
		logic [WORD_W-1:0] duty;
	} window_res_t;

endpackage

`default_nettype wire

### rtl/essr_if.sv
// Valid/ready channel interfaces: event input, result output, register writes.
// Depends on essr_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface essr_evt_if import essr_pkg::*;;
	logic                valid;
	logic                ready;
	logic [MODE_W-1:0]   mode;
	logic [SAMPLE_W-1:0] adc_sample;

	modport source (output valid, output mode, output adc_sample, input ready);
	modport sink (input valid, input mode, input adc_sample, output ready);
endinterface

interface essr_res_if import essr_pkg::*;;
	logic              valid;
	logic              ready;
	logic [WORD_W-1:0] duty;
	logic [WORD_W-1:0] measured_rpm;
	logic [WORD_W-1:0] target_speed;
	logic              window_done;

	modport source (output valid, output duty, output measured_rpm,
		output target_speed, output window_done, input ready);
	modport sink (input valid, input duty, input measured_rpm,
		input target_speed, input window_done, output ready);
endinterface

interface essr_cfg_if import essr_pkg::*;;
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [CFG_DAT_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

### rtl/encoder_speed_step_regulator.sv
// Top level of the encoder speed step regulator: config registers, event input
// register, state update and result register. Depends on essr_pkg, essr_if,
// essr_target_scale, essr_window_close.
//
//  channel | dir | payload                                      | moves
//  evt     | in  | mode, adc_sample                             | one event word
//  res     | out | duty, measured_rpm, target_speed, window_done | one result word
//  cfg     | in  | index, data                                  | one register write
//
// Result registered after the input register; one event per cycle sustained while res.ready holds.
// An event is held in the input register, then state and the result register
// update together; the window multiply and the ADC scale sit there.
// cfg is always ready. duty_initial is accepted but only the fixed reset value
// loads the duty word. arst_n clears control and state to their reset values.
// A stalled result holds its register; the input register still takes one word.
`timescale 1ns / 1ps
`default_nettype none

module encoder_speed_step_regulator import essr_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	essr_evt_if.sink   evt,
	essr_res_if.source res,
	essr_cfg_if.sink   cfg
);

	// configuration
	logic [WORD_W-1:0] window_ticks_q;
	logic [PPR_W-1:0]  pulses_per_rev_q;
	logic [RPR_W-1:0]  rpm_per_rev_q;
	logic [STEP_W-1:0] duty_step_q;
	logic [WORD_W-1:0] duty_max_q;
	logic [WORD_W-1:0] full_scale_q;

	// state
	logic [PPR_W-1:0]  pulse_count_q;
	logic [WORD_W-1:0] rev_count_q;
	logic [WORD_W-1:0] tick_count_q;
	logic [WORD_W-1:0] duty_q;
	logic [WORD_W-1:0] target_q;
	logic [WORD_W-1:0] rpm_q;

	// input register
	logic                v_s1;
	logic [MODE_W-1:0]   mode_s1;
	logic [SAMPLE_W-1:0] sample_s1;

	// result register
	logic              out_valid_q;
	logic              done_q;

	logic advance;

	logic [WORD_W:0]   tick_inc;
	logic [PPR_W:0]    pulse_inc;
	logic              close;
	window_res_t       win;
	logic [WORD_W-1:0] target_new;

	logic [PPR_W-1:0]  pulse_nx;
	logic [WORD_W-1:0] rev_nx;
	logic [WORD_W-1:0] tick_nx;
	logic [WORD_W-1:0] duty_nx;
	logic [WORD_W-1:0] target_nx;
	logic [WORD_W-1:0] rpm_nx;

	assign advance   = v_s1 && (!out_valid_q || res.ready);
	assign evt.ready = !v_s1 || advance;
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_ticks_q   <= WINDOW_TICKS_RST;
			pulses_per_rev_q <= PULSES_PER_REV_RST;
			rpm_per_rev_q    <= RPM_PER_REV_RST;
			duty_step_q      <= DUTY_STEP_RST;
			duty_max_q       <= DUTY_MAX_RST;
			full_scale_q     <= FULL_SCALE_RST;
		end else if (cfg.valid) begin
			case (cfg_idx_t'(cfg.index))
				REG_WINDOW_TICKS:   window_ticks_q   <= cfg.data[WORD_W-1:0];
				REG_PULSES_PER_REV: pulses_per_rev_q <= cfg.data[PPR_W-1:0];
				REG_RPM_PER_REV:    rpm_per_rev_q    <= cfg.data[RPR_W-1:0];
				REG_DUTY_STEP:      duty_step_q      <= cfg.data[STEP_W-1:0];
				REG_DUTY_MAX:       duty_max_q       <= cfg.data[WORD_W-1:0];
				REG_FULL_SCALE:     full_scale_q     <= cfg.data[WORD_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (evt.ready) begin
			v_s1 <= evt.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (evt.valid && evt.ready) begin
			mode_s1   <= evt.mode;
			sample_s1 <= evt.adc_sample;
		end
	end

	essr_target_scale u_target_scale (
		.sample     (sample_s1),
		.full_scale (full_scale_q),
		.target     (target_new)
	);

	essr_window_close u_window_close (
		.rev_count   (rev_count_q),
		.rpm_per_rev (rpm_per_rev_q),
		.target      (target_q),
		.duty        (duty_q),
		.duty_step   (duty_step_q),
		.duty_max    (duty_max_q),
		.res         (win)
	);

	always_comb begin
		tick_inc  = 17'(tick_count_q) + 17'd1;
		pulse_inc = 7'(pulse_count_q) + 7'd1;
		close     = 1'b0;
		pulse_nx  = pulse_count_q;
		rev_nx    = rev_count_q;
		tick_nx   = tick_count_q;
		duty_nx   = duty_q;
		target_nx = target_q;
		rpm_nx    = rpm_q;
		case (mode_s1)
			MODE_TICK: begin
				if (tick_inc >= 17'(window_ticks_q)) begin
					close   = 1'b1;
					tick_nx = '0;
					rev_nx  = '0;
					rpm_nx  = win.rpm;
					duty_nx = win.duty;
				end else begin
					tick_nx = tick_inc[WORD_W-1:0];
				end
			end
			MODE_PULSE: begin
				if (pulse_inc >= 7'(pulses_per_rev_q)) begin
					pulse_nx = '0;
					if (rev_count_q != WORD_MAX) begin
						rev_nx = rev_count_q + 16'd1;
					end
				end else begin
					pulse_nx = pulse_inc[PPR_W-1:0];
				end
			end
			MODE_ADC: begin
				target_nx = target_new;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pulse_count_q <= '0;
			rev_count_q   <= '0;
			tick_count_q  <= '0;
			duty_q        <= DUTY_INITIAL_RST;
			target_q      <= '0;
			rpm_q         <= '0;
			done_q        <= 1'b0;
		end else if (advance) begin
			pulse_count_q <= pulse_nx;
			rev_count_q   <= rev_nx;
			tick_count_q  <= tick_nx;
			duty_q        <= duty_nx;
			target_q      <= target_nx;
			rpm_q         <= rpm_nx;
			done_q        <= close;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// state registers double as the result word
	assign res.valid        = out_valid_q;
	assign res.duty         = duty_q;
	assign res.measured_rpm = rpm_q;
	assign res.target_speed = target_q;
	assign res.window_done  = done_q;

endmodule

`default_nettype wire

### rtl/essr_target_scale.sv
// ADC reading to target speed: sample * full_scale / 4095, small targets forced to 50.
// Division by 4095 uses the 2^12-1 identity, no divider. Depends on essr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module essr_target_scale import essr_pkg::*; (
	input  wire logic [SAMPLE_W-1:0] sample,
	input  wire logic [WORD_W-1:0]   full_scale,
	output      logic [WORD_W-1:0]   target
);

	logic [27:0] prod;
	logic [16:0] s1;
	logic [12:0] s2;
	logic [16:0] quo;

	// p = a*4096 + b = a*4095 + (a+b); fold twice, then one compare
	always_comb begin
		prod = 28'(sample) * 28'(full_scale);
		s1   = 17'(prod[27:12]) + 17'(prod[11:0]);
		s2   = 13'(s1[16:12]) + 13'(s1[11:0]);
		quo  = 17'(prod[27:12]) + 17'(s1[16:12]) + 17'(s2 >= ADC_FULL);
		if (quo[15:0] < TARGET_FLOOR) begin
			target = TARGET_SUBST;
		end else begin
			target = quo[15:0];
		end
	end

endmodule

`default_nettype wire

### rtl/essr_window_close.sv
// Window close: RPM from revolutions (saturating) and one duty step toward target.
// Depends on essr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module essr_window_close import essr_pkg::*; (
	input  wire logic [WORD_W-1:0] rev_count,
	input  wire logic [RPR_W-1:0]  rpm_per_rev,
	input  wire logic [WORD_W-1:0] target,
	input  wire logic [WORD_W-1:0] duty,
	input  wire logic [STEP_W-1:0] duty_step,
	input  wire logic [WORD_W-1:0] duty_max,
	output      window_res_t       res
);

	logic [23:0]       prod;
	logic [WORD_W-1:0] rpm;
	logic [WORD_W:0]   d;

	always_comb begin
		prod = 24'(rev_count) * 24'(rpm_per_rev);
		rpm  = (prod[23:16] != '0) ? WORD_MAX : prod[15:0];
		if (rpm < target) begin
			d = 17'(duty) + 17'(duty_step);
		end else if (rpm > target) begin
			d = (duty > 16'(duty_step)) ? 17'(duty - 16'(duty_step)) : '0;
		end else begin
			d = 17'(duty);
		end
		res.rpm  = rpm;
		res.duty = (d > 17'(duty_max)) ? duty_max : d[15:0];
	end

endmodule

`default_nettype wire

### rtl/essr_checker.sv
// Port-level checks for encoder_speed_step_regulator, attached by bind.
// Depends on the top level's channel ports only.
`timescale 1ns / 1ps
`default_nettype none

module essr_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        evt_ready,
	input wire logic        res_valid,
	input wire logic        res_ready,
	input wire logic [15:0] duty,
	input wire logic [15:0] measured_rpm,
	input wire logic [15:0] target_speed,
	input wire logic        window_done
);

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("result word dropped while stalled");

	a_res_stable: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> $stable(duty) && $stable(measured_rpm)
			&& $stable(target_speed) && $stable(window_done))
		else $error("stalled result word changed");

	// input only backs up when a finished result is waiting
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!evt_ready |-> res_valid && !res_ready)
		else $error("event input stalled without a waiting result");

	a_target_floor: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> target_speed == 16'd0 || target_speed == 16'd50
			|| target_speed >= 16'd100)
		else $error("target below floor not substituted");

endmodule

bind encoder_speed_step_regulator essr_checker u_essr_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.evt_ready    (evt.ready),
	.res_valid    (res.valid),
	.res_ready    (res.ready),
	.duty         (res.duty),
	.measured_rpm (res.measured_rpm),
	.target_speed (res.target_speed),
	.window_done  (res.window_done)
);

`default_nettype wire
